>>> hdl/wfpa_pkg.sv
package wfpa_pkg;

  localparam int MEM_SIZE_DEF  = 4096;
  localparam int MAX_PARTS_DEF = 64;

  localparam int SIZE_W  = 13;
  localparam int ADDR_W  = 12;
  localparam int ID_W    = 8;
  localparam int STAT_W  = 3;

  localparam logic [ID_W-1:0] ID_RESERVED = 8'd32;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_TOO_BIG   = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUP       = 3'd2;
  localparam logic [STAT_W-1:0] ST_NO_SPACE  = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd5;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the request
    logic scan_clr;   // restart the table scan
    logic scan_step;  // examine the entry whose read data is now valid
    logic decide;     // register the decision from scan results
    logic wr_free;    // rewrite the found entry as free
    logic shift_step; // move one entry down over the removed hole
    logic wr_new;     // append the allocated entry
    logic wr_rem;     // append the remainder hole
    logic finish;     // write the result register
  } wfpa_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic shift_done;
    logic do_free;    // free request found its id
    logic do_hole;    // allocation reuses a hole
    logic do_tail;    // allocation at the tail
    logic has_rem;    // hole leaves a remainder
  } wfpa_stat_t;

endpackage

>>> hdl/wfpa_if.sv
interface wfpa_in_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [wfpa_pkg::ID_W-1:0]  part_id;
  logic [wfpa_pkg::SIZE_W-1:0] req_size;
  modport source (output valid, opcode, part_id, req_size, input ready);
  modport sink   (input valid, opcode, part_id, req_size, output ready);
endinterface

interface wfpa_out_if;
  logic                        valid;
  logic                        ready;
  logic [wfpa_pkg::STAT_W-1:0] status;
  logic [wfpa_pkg::ADDR_W-1:0] start_addr;
  modport source (output valid, status, start_addr, input ready);
  modport sink   (input valid, status, start_addr, output ready);
endinterface

>>> hdl/wfpa_ram.sv
module wfpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/wfpa_ctrl.sv
module wfpa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                out_busy,
  input  wfpa_pkg::wfpa_stat_t st,
  output wfpa_pkg::wfpa_cmd_t  cmd,
  output logic                idle
);
  import wfpa_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_ACT   = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_NEW   = 3'd5;
  localparam logic [2:0] S_REM   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    idle      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        idle = 1'b1;
        if (in_fire) begin
          cmd.load     = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (st.scan_done) begin
          state_nxt = S_DEC;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_DEC: begin
        cmd.decide = 1'b1;
        state_nxt  = S_ACT;
      end
      S_ACT: begin
        if (st.do_free) begin
          cmd.wr_free = 1'b1;
          state_nxt   = S_DONE;
        end else if (st.do_hole) begin
          state_nxt = S_SHIFT;
        end else if (st.do_tail) begin
          state_nxt = S_NEW;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT: begin
        if (st.shift_done) begin
          state_nxt = S_NEW;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      S_NEW: begin
        cmd.wr_new = 1'b1;
        state_nxt  = st.has_rem ? S_REM : S_DONE;
      end
      S_REM: begin
        cmd.wr_rem = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

>>> hdl/wfpa_dp.sv
module wfpa_dp #(
  parameter int MEM_SIZE  = wfpa_pkg::MEM_SIZE_DEF,
  parameter int MAX_PARTS = wfpa_pkg::MAX_PARTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wfpa_pkg::wfpa_cmd_t           cmd,
  output wfpa_pkg::wfpa_stat_t          st,
  input  logic                          cfg_we,
  input  logic [wfpa_pkg::SIZE_W-1:0]   cfg_wdata,
  input  logic                          in_opcode,
  input  logic [wfpa_pkg::ID_W-1:0]     in_part_id,
  input  logic [wfpa_pkg::SIZE_W-1:0]   in_req_size,
  output logic [wfpa_pkg::STAT_W-1:0]   res_status,
  output logic [wfpa_pkg::ADDR_W-1:0]   res_addr,
  output logic [$clog2(MAX_PARTS+1)-1:0] count
);
  import wfpa_pkg::*;

  localparam int IW = $clog2(MAX_PARTS);
  localparam int CW = $clog2(MAX_PARTS + 1);
  localparam int SW = $clog2(MEM_SIZE + 1);
  localparam int EW = SW + 1;
  localparam int XW = (SW > SIZE_W) ? SW : SIZE_W;
  // entry layout: start, size, id, free
  localparam int EWID = SW + SW + ID_W + 1;

  logic [EWID-1:0] rd_data, wr_data;
  logic [IW-1:0]   raddr, waddr;
  logic            we;

  wfpa_ram #(.WIDTH(EWID), .DEPTH(MAX_PARTS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wr_data), .raddr(raddr), .rdata(rd_data)
  );

  logic [SW-1:0]   e_start, e_size;
  logic [ID_W-1:0] e_id;
  logic            e_free;
  assign {e_start, e_size, e_id, e_free} = rd_data;

  logic [SIZE_W-1:0] total_r;
  logic              op_r;
  logic [ID_W-1:0]   id_r;
  logic [SIZE_W-1:0] req_r;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     ptr_r;     // next address to read
  logic [CW-1:0]     exam_r;    // index of entry in rd_data
  logic              rd_vld_r;
  logic              found_r;
  logic [IW-1:0]     found_idx_r;
  logic [SW-1:0]     fsize_r;
  logic              hole_ok_r;
  logic [SW-1:0]     best_r;
  logic [IW-1:0]     best_idx_r;
  logic [SW-1:0]     best_start_r;
  logic [SW-1:0]     hstart_r;
  logic [EW-1:0]     hi_r;
  logic [STAT_W-1:0] stat_r;
  logic [SW-1:0]     addr_r;
  logic              do_free_r, do_hole_r, do_tail_r, has_rem_r;
  logic [CW-1:0]     sh_r;      // destination of the next shift move
  logic              sh_vld_r;
  logic [STAT_W-1:0] res_status_r;
  logic [ADDR_W-1:0] res_addr_r;

  assign count      = cnt_r;
  assign res_status = res_status_r;
  assign res_addr   = res_addr_r;

  logic [XW-1:0] tot_eff;
  assign tot_eff = (XW'(total_r) > XW'(MEM_SIZE)) ? XW'(MEM_SIZE) : XW'(total_r);

  logic [EW-1:0] tail;
  assign tail = (hi_r < EW'(tot_eff)) ? EW'(tot_eff) - hi_r : '0;

  logic scan_done;
  assign scan_done = (ptr_r >= cnt_r) && !rd_vld_r;

  logic [EW-1:0] e_end;
  assign e_end = EW'(e_start) + EW'(e_size);

  // Read address: scan pointer while scanning, shift source while shifting.
  // During a move the entry two above the destination is fetched for the next move.
  always_comb begin
    raddr = ptr_r[IW-1:0];
    if (cmd.shift_step && sh_vld_r) begin
      raddr = IW'(sh_r + CW'(2));
    end else if (cmd.shift_step || do_hole_r) begin
      raddr = IW'(sh_r + CW'(1));
    end
  end

  logic [EW-1:0] hsz_e;
  assign hsz_e = EW'(best_r);

  always_comb begin
    we      = 1'b0;
    waddr   = '0;
    wr_data = rd_data;
    if (cmd.wr_free) begin
      we      = 1'b1;
      waddr   = found_idx_r;
      wr_data = {hstart_r, fsize_r, ID_RESERVED, 1'b1};
    end else if (cmd.shift_step && sh_vld_r) begin
      we      = 1'b1;
      waddr   = sh_r[IW-1:0];
      wr_data = rd_data;
    end else if (cmd.wr_new) begin
      we      = 1'b1;
      waddr   = do_hole_r ? IW'(cnt_r - CW'(1)) : cnt_r[IW-1:0];
      wr_data = {addr_r, SW'(req_r), id_r, 1'b0};
    end else if (cmd.wr_rem) begin
      we      = 1'b1;
      waddr   = cnt_r[IW-1:0];
      wr_data = {SW'(best_start_r + SW'(req_r)), SW'(best_r - SW'(req_r)), ID_RESERVED, 1'b1};
    end
  end

  assign st.scan_done  = scan_done;
  assign st.shift_done = (sh_r + CW'(1) >= cnt_r);
  assign st.do_free    = do_free_r;
  assign st.do_hole    = do_hole_r;
  assign st.do_tail    = do_tail_r;
  assign st.has_rem    = has_rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= SIZE_W'(MEM_SIZE);
      cnt_r   <= '0;
    end else begin
      if (cfg_we) begin
        total_r <= cfg_wdata;
      end
      if (cmd.shift_step && sh_vld_r) begin
        cnt_r <= cnt_r;
      end
      if (cmd.wr_new) begin
        cnt_r <= do_hole_r ? cnt_r : cnt_r + CW'(1);
      end
      if (cmd.wr_rem) begin
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_opcode;
      id_r  <= in_part_id;
      req_r <= in_req_size;
    end
    if (cmd.scan_clr) begin
      ptr_r     <= '0;
      rd_vld_r  <= 1'b0;
      found_r   <= 1'b0;
      hole_ok_r <= 1'b0;
      best_r    <= '0;
      hi_r      <= '0;
      do_free_r <= 1'b0;
      do_hole_r <= 1'b0;
      do_tail_r <= 1'b0;
      has_rem_r <= 1'b0;
    end else if (cmd.scan_step) begin
      rd_vld_r <= (ptr_r < cnt_r);
      exam_r   <= ptr_r;
      if (ptr_r < cnt_r) begin
        ptr_r <= ptr_r + CW'(1);
      end
      if (rd_vld_r) begin
        if (!found_r && e_id == id_r) begin
          found_r     <= 1'b1;
          found_idx_r <= exam_r[IW-1:0];
          hstart_r    <= e_start;
          fsize_r     <= e_size;
        end
        if (e_free && e_size > best_r) begin
          best_r       <= e_size;
          best_idx_r   <= exam_r[IW-1:0];
          best_start_r <= e_start;
          hole_ok_r    <= 1'b1;
        end
        if (e_end > hi_r) begin
          hi_r <= e_end;
        end
      end
    end
    if (cmd.decide) begin
      do_free_r <= 1'b0;
      do_hole_r <= 1'b0;
      do_tail_r <= 1'b0;
      has_rem_r <= 1'b0;
      addr_r    <= '0;
      stat_r    <= ST_OK;
      sh_r      <= CW'(best_idx_r);
      sh_vld_r  <= 1'b0;
      if (op_r == OP_FREE) begin
        if (id_r == ID_RESERVED || !found_r) begin
          stat_r <= ST_NOT_FOUND;
        end else begin
          do_free_r <= 1'b1;
          addr_r    <= hstart_r;
        end
      end else if (XW'(req_r) > tot_eff) begin
        stat_r <= ST_TOO_BIG;
      end else if (id_r == ID_RESERVED || found_r) begin
        stat_r <= ST_DUP;
      end else if (hole_ok_r && hsz_e >= tail) begin
        if (req_r == '0 || best_r < SW'(req_r)) begin
          stat_r <= ST_NO_SPACE;
        end else if (best_r > SW'(req_r) && cnt_r >= CW'(MAX_PARTS)) begin
          stat_r <= ST_FULL;
        end else begin
          do_hole_r <= 1'b1;
          has_rem_r <= best_r > SW'(req_r);
          addr_r    <= best_start_r;
        end
      end else begin
        if (req_r == '0 || tail < EW'(req_r)) begin
          stat_r <= ST_NO_SPACE;
        end else if (cnt_r >= CW'(MAX_PARTS)) begin
          stat_r <= ST_FULL;
        end else begin
          do_tail_r <= 1'b1;
          addr_r    <= SW'(hi_r);
        end
      end
    end
    // The first shift cycle only waits for the entry above the hole at the read port.
    if (cmd.shift_step) begin
      if (!sh_vld_r) begin
        sh_vld_r <= 1'b1;
      end else begin
        sh_r     <= sh_r + CW'(1);
      end
    end
    if (cmd.finish) begin
      res_status_r <= stat_r;
      res_addr_r   <= (stat_r == ST_OK) ? ADDR_W'(addr_r) : '0;
    end
  end
endmodule

>>> hdl/worst_fit_partition_allocator_core.sv
// Worst-fit partition allocator.
// Requests enter on the in_ channel (opcode, part_id, req_size) with a
// valid/ready handshake; one result (status, start_addr) leaves on the out_
// channel for each request. One request is worked at a time.
// The partition table sits in a RAM with a registered read that is scanned
// one entry per cycle for the id, the largest free hole and the highest end.
// After acceptance the table is scanned and a decision is registered. A
// rejected request then goes to the result, a free rewrites the found entry,
// a tail allocation appends the new entry, and for a reused hole the entries
// above it move down one per cycle; then the entry and any remainder follow.
// The result is held in an output register; the next request is accepted the
// cycle after the result has been written there, even while the receiver
// stalls, and its own result waits until the register is emptied.
// Reset empties the table and sets total_size to MEM_SIZE. The cfg_ write
// updates total_size and is meant to be used while the block is idle.
module worst_fit_partition_allocator_core #(
  parameter int MEM_SIZE  = wfpa_pkg::MEM_SIZE_DEF,
  parameter int MAX_PARTS = wfpa_pkg::MAX_PARTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [wfpa_pkg::SIZE_W-1:0] cfg_wdata,
  wfpa_in_if.sink                     in_ch,
  wfpa_out_if.source                  out_ch
);
  import wfpa_pkg::*;

  wfpa_cmd_t  cmd;
  wfpa_stat_t st;
  logic       idle;
  logic       in_fire;
  logic       out_vld_r;
  logic [STAT_W-1:0] res_status;
  logic [ADDR_W-1:0] res_addr;
  logic [$clog2(MAX_PARTS+1)-1:0] count;

  assign in_ch.ready = idle;
  assign in_fire     = in_ch.valid && idle;

  wfpa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
    .out_busy(out_vld_r && !out_ch.ready), .st(st), .cmd(cmd), .idle(idle)
  );

  wfpa_dp #(.MEM_SIZE(MEM_SIZE), .MAX_PARTS(MAX_PARTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_opcode(in_ch.opcode), .in_part_id(in_ch.part_id), .in_req_size(in_ch.req_size),
    .res_status(res_status), .res_addr(res_addr), .count(count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.finish) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.status     = res_status;
  assign out_ch.start_addr = res_addr;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count <= ($clog2(MAX_PARTS+1))'(MAX_PARTS)) else $error("entry count overflow");
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(out_vld_r && !out_ch.ready)) else $error("result overwritten");
  a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_ch.status != ST_OK |-> out_ch.start_addr == '0)
    else $error("address on error");
endmodule

>>> verif/worst_fit_partition_allocator_core_test.sv
`timescale 1ns / 100ps

module worst_fit_partition_allocator_core_test;
  import wfpa_pkg::*;

  typedef struct {
    logic               op;
    logic [ID_W-1:0]    id;
    logic [SIZE_W-1:0]  size;
  } request_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] addr;
  } outcome_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;

  wfpa_in_if  in_ch ();
  wfpa_out_if out_ch ();

  worst_fit_partition_allocator_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Shadow copy of the partition table.
  int unsigned pt_start [MAX_PARTS_DEF];
  int unsigned pt_size  [MAX_PARTS_DEF];
  int unsigned pt_id    [MAX_PARTS_DEF];
  bit          pt_free  [MAX_PARTS_DEF];
  int unsigned n_parts;
  int unsigned seg_size;

  request_t pending [$];
  outcome_t expected_results [$];
  int mismatches;
  int gap_left;
  int stall_left;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void table_add(int unsigned s, int unsigned sz, int unsigned id, bit fr);
    pt_start[n_parts] = s;
    pt_size[n_parts]  = sz;
    pt_id[n_parts]    = id;
    pt_free[n_parts]  = fr;
    n_parts++;
  endfunction

  function automatic outcome_t allocate_or_free(request_t rq);
    outcome_t res;
    int found, hole;
    int unsigned lim, hi, tail, space, best, hs, hz, req, id;
    res.status = ST_OK;
    res.addr = '0;
    req = rq.size;
    id = rq.id;
    found = -1;
    for (int i = 0; i < n_parts; i++)
      if (found < 0 && pt_id[i] == id) found = i;
    if (rq.op == OP_FREE) begin
      if (id == ID_RESERVED || found < 0) begin
        res.status = ST_NOT_FOUND;
      end else begin
        pt_free[found] = 1'b1;
        pt_id[found] = ID_RESERVED;
        res.addr = pt_start[found][ADDR_W-1:0];
      end
      return res;
    end
    lim = (seg_size > MEM_SIZE_DEF) ? MEM_SIZE_DEF : seg_size;
    if (req > lim) begin
      res.status = ST_TOO_BIG;
      return res;
    end
    if (id == ID_RESERVED || found >= 0) begin
      res.status = ST_DUP;
      return res;
    end
    hi = 0;
    best = 0;
    hole = -1;
    for (int i = 0; i < n_parts; i++) begin
      if (pt_start[i] + pt_size[i] > hi) hi = pt_start[i] + pt_size[i];
      if (pt_free[i] && pt_size[i] > best) begin
        best = pt_size[i];
        hole = i;
      end
    end
    // A segment shrunk below the highest end leaves no tail at all.
    tail = (hi < lim) ? lim - hi : 0;
    if (hole >= 0 && pt_size[hole] >= tail) begin
      space = pt_size[hole];
    end else begin
      hole = -1;
      space = tail;
    end
    if (req == 0 || space < req) begin
      res.status = ST_NO_SPACE;
    end else if (hole >= 0) begin
      hs = pt_start[hole];
      hz = pt_size[hole];
      if (n_parts + ((hz > req) ? 1 : 0) > MAX_PARTS_DEF) begin
        res.status = ST_FULL;
      end else begin
        for (int i = hole; i < n_parts - 1; i++) begin
          pt_start[i] = pt_start[i+1];
          pt_size[i]  = pt_size[i+1];
          pt_id[i]    = pt_id[i+1];
          pt_free[i]  = pt_free[i+1];
        end
        n_parts--;
        table_add(hs, req, id, 1'b0);
        if (hz > req) table_add(hs + req, hz - req, ID_RESERVED, 1'b1);
        res.addr = hs[ADDR_W-1:0];
      end
    end else if (n_parts + 1 > MAX_PARTS_DEF) begin
      res.status = ST_FULL;
    end else begin
      table_add(hi, req, id, 1'b0);
      res.addr = hi[ADDR_W-1:0];
    end
    return res;
  endfunction

  // Request driver.
  always @(posedge clk) begin
    request_t rq;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        rq.op = in_ch.opcode;
        rq.id = in_ch.part_id;
        rq.size = in_ch.req_size;
        expected_results.push_back(allocate_or_free(rq));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending.size() > 0) begin
          rq = pending.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.opcode <= rq.op;
          in_ch.part_id <= rq.id;
          in_ch.req_size <= rq.size;
          gap_left = random_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls.
  always @(posedge clk) begin
    outcome_t exp_r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status %0d addr %0d", out_ch.status, out_ch.start_addr);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_ch.status !== exp_r.status || out_ch.start_addr !== exp_r.addr) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected status %0d addr %0d, got status %0d addr %0d",
                       exp_r.status, exp_r.addr, out_ch.status, out_ch.start_addr);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = ($urandom_range(0, 3) == 0) ? random_gap() : 0;
      end
    end
  end

  task automatic add_request(logic op, int unsigned id, int unsigned size);
    request_t rq;
    rq.op = op;
    rq.id = id[ID_W-1:0];
    rq.size = size[SIZE_W-1:0];
    pending.push_back(rq);
  endtask

  task automatic add_random(int count);
    int r;
    int unsigned id, size;
    for (int k = 0; k < count; k++) begin
      id = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 47) : $urandom_range(0, 255);
      r = $urandom_range(0, 99);
      if (r < 70) size = $urandom_range(1, 64);
      else if (r < 90) size = $urandom_range(1, 600);
      else if (r < 95) size = $urandom_range(0, 8191);
      else size = $urandom_range(2000, 4096);
      add_request(($urandom_range(0, 99) < 35) ? OP_FREE : OP_ALLOC, id, size);
    end
  endtask

  // Waits until every request has been answered and the block is quiet.
  task automatic drain();
    while (pending.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_segment(int unsigned v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v[SIZE_W-1:0];
    seg_size = v & 13'h1FFF;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = 1'b0;
    in_ch.part_id = '0;
    in_ch.req_size = '0;
    out_ch.ready = 1'b0;
    mismatches = 0;
    n_parts = 0;
    seg_size = MEM_SIZE_DEF;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    set_segment(4096);

    // Directed corner requests.
    add_request(OP_ALLOC, ID_RESERVED, 10);
    add_request(OP_FREE, ID_RESERVED, 0);
    add_request(OP_ALLOC, 5, 0);
    add_request(OP_ALLOC, 5, 4097);
    add_request(OP_ALLOC, 5, 8191);
    add_request(OP_ALLOC, 0, 4096);
    add_request(OP_ALLOC, 1, 1);
    add_request(OP_ALLOC, 0, 5);
    add_request(OP_FREE, 0, 8191);
    add_request(OP_ALLOC, 255, 100);
    add_request(OP_ALLOC, 255, 100);
    add_request(OP_FREE, 7, 0);
    add_request(OP_ALLOC, 1, 3996);
    add_request(OP_ALLOC, 2, 1);
    add_request(OP_FREE, 255, 0);
    add_request(OP_ALLOC, 170, 100);
    add_request(OP_FREE, 1, 0);
    add_request(OP_FREE, 170, 0);
    add_request(OP_FREE, 1, 0);
    drain();

    // Fill the table with single-byte partitions until it is full.
    for (int i = 60; i < 130; i++) add_request(OP_ALLOC, i, 1);
    for (int i = 60; i < 64; i++) add_request(OP_FREE, i, 0);
    add_request(OP_ALLOC, 200, 1);
    add_request(OP_ALLOC, 201, 3);
    drain();
    for (int i = 60; i < 130; i++) add_request(OP_FREE, i, 0);
    add_request(OP_FREE, 200, 0);
    drain();

    add_random(700);
    drain();
    set_segment(1);
    add_random(100);
    drain();
    set_segment(8191);
    add_random(450);
    drain();
    // Shrinks the segment below the highest end.
    set_segment(300);
    add_random(350);
    drain();
    set_segment(4096);
    add_random(200);
    drain();

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
